>>> src/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

    // Default number of slots in the element store
    localparam int DQ_CAPACITY = 16;

    // Depth of the command queue between front end and back end
    localparam int CMD_FIFO_DEPTH = 2;

    localparam int VALUE_W = 32;

    // Request codes as they arrive on the request channel
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_REAR   = 3'd3;
    localparam logic [2:0] REQ_LIST       = 3'd4;

    // Decoded operation carried to the back end
    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_REAR,
        OP_POP_FRONT,
        OP_POP_REAR,
        OP_LIST
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL
    } status_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP,
        BK_LIST
    } bk_state_t;

    typedef struct packed {
        logic [2:0]                req_type;
        logic signed [VALUE_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] item_value;
        logic                      last_of_run;
    } rsp_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

>>> src/dq_front.sv
// Request front end: accepts transactions, decodes them, drops unknown codes.
module dq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dq_pkg::req_t  req,
    output logic          cmd_push,
    output dq_pkg::cmd_t  cmd,
    input  logic          cmd_full
);
    import dq_pkg::*;

    logic  front_valid_reg;
    logic  front_valid_next;
    cmd_t  front_cmd_reg;
    logic  known;
    op_t   dec_op;

    // Decode request code
    always_comb
    begin
        known  = 1'b1;
        dec_op = OP_LIST;
        case (req.req_type)
            REQ_PUSH_FRONT: dec_op = OP_PUSH_FRONT;
            REQ_PUSH_REAR:  dec_op = OP_PUSH_REAR;
            REQ_POP_FRONT:  dec_op = OP_POP_FRONT;
            REQ_POP_REAR:   dec_op = OP_POP_REAR;
            REQ_LIST:       dec_op = OP_LIST;
            default:        known  = 1'b0;
        endcase
    end

    // Holding register stalls only when it is full and the queue is full
    assign req_stall = front_valid_reg && cmd_full;
    assign cmd_push  = front_valid_reg && !cmd_full;
    assign cmd       = front_cmd_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (!req_stall)
        begin
            front_valid_next = req_valid && known;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            front_cmd_reg.op    <= dec_op;
            front_cmd_reg.value <= req.push_value;
        end
    end

endmodule

>>> src/dq_cmd_fifo.sv
// Short command queue between the front end and the back end.
module dq_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dq_pkg::cmd_t  push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output dq_pkg::cmd_t  head
);
    import dq_pkg::*;

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             entry_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (fill_reg == CNT_W'(CMD_FIFO_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/dq_back.sv
// Back end: element store, front index and count, result sequencing.
module dq_back #(
    parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  dq_pkg::cmd_t  cmd,
    output logic          cmd_pop,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dq_pkg::rsp_t  rsp
);
    import dq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = IDX_W + 1;

    // Slot store
    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rd_data_reg;

    bk_state_t          state_reg;
    bk_state_t          state_next;
    logic [IDX_W-1:0]   front_reg;
    logic [IDX_W-1:0]   front_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   walk_reg;
    logic [IDX_W-1:0]   walk_next;
    logic               out_valid_reg;
    rsp_t               out_data_reg;
    rsp_t               out_data_next;
    logic               out_load;
    logic               out_free;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    logic               is_full;
    logic               is_empty;
    logic [SUM_W-1:0]   front_ext;
    logic [SUM_W-1:0]   count_ext;
    logic [IDX_W-1:0]   front_dec;
    logic [IDX_W-1:0]   front_inc;
    logic [IDX_W-1:0]   rear_slot;
    logic [IDX_W-1:0]   last_slot;
    logic [IDX_W-1:0]   walk_slot;
    logic               walk_last;
    logic               is_push;

    // Fold a sum below twice the capacity back into the slot range
    function automatic logic [IDX_W-1:0] wrap_slot(input logic [SUM_W-1:0] pos);
        logic [SUM_W-1:0] cap_w;
        cap_w = SUM_W'(CAPACITY);
        return (pos >= cap_w) ? IDX_W'(pos - cap_w) : IDX_W'(pos);
    endfunction

    // Slot arithmetic
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign front_ext = SUM_W'(front_reg);
    assign count_ext = SUM_W'(count_reg);
    assign front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - 1'b1;
    assign front_inc = wrap_slot(front_ext + 1'b1);
    assign rear_slot = wrap_slot(front_ext + count_ext);
    assign last_slot = wrap_slot(front_ext + count_ext - 1'b1);
    assign walk_slot = wrap_slot(front_ext + SUM_W'(walk_reg) + 1'b1);
    assign walk_last = ((CNT_W'(walk_reg) + 1'b1) == count_reg);
    assign is_push   = (cmd.op == OP_PUSH_FRONT) || (cmd.op == OP_PUSH_REAR);

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free && !is_empty)
                begin
                    if ((cmd.op == OP_POP_FRONT) || (cmd.op == OP_POP_REAR))
                    begin
                        state_next = BK_POP;
                    end
                    else if (cmd.op == OP_LIST)
                    begin
                        state_next = BK_LIST;
                    end
                end
            end
            BK_POP:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_LIST:
            begin
                if (out_free && walk_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath control and result formation
    always_comb
    begin
        cmd_pop       = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = front_reg;
        rd_en         = 1'b0;
        rd_addr       = front_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        walk_next     = walk_reg;
        out_load      = 1'b0;
        out_data_next.status      = ST_OK;
        out_data_next.item_value  = '0;
        out_data_next.last_of_run = 1'b1;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_PUSH_FRONT, OP_PUSH_REAR:
                        begin
                            out_load                 = 1'b1;
                            out_data_next.item_value = cmd.value;
                            if (is_full)
                            begin
                                out_data_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (cmd.op == OP_PUSH_FRONT)
                                begin
                                    wr_addr    = front_dec;
                                    front_next = front_dec;
                                end
                                else
                                begin
                                    wr_addr = rear_slot;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR:
                        begin
                            if (is_empty)
                            begin
                                out_load             = 1'b1;
                                out_data_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                count_next = count_reg - 1'b1;
                                if (cmd.op == OP_POP_FRONT)
                                begin
                                    rd_addr    = front_reg;
                                    front_next = front_inc;
                                end
                                else
                                begin
                                    rd_addr = last_slot;
                                end
                            end
                        end
                        OP_LIST:
                        begin
                            if (is_empty)
                            begin
                                out_load             = 1'b1;
                                out_data_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en     = 1'b1;
                                rd_addr   = front_reg;
                                walk_next = '0;
                            end
                        end
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            BK_POP:
            begin
                if (out_free)
                begin
                    out_load                 = 1'b1;
                    out_data_next.item_value = rd_data_reg;
                end
            end
            BK_LIST:
            begin
                if (out_free)
                begin
                    out_load                  = 1'b1;
                    out_data_next.item_value  = rd_data_reg;
                    out_data_next.last_of_run = walk_last;
                    if (!walk_last)
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = walk_slot;
                        walk_next = walk_reg + 1'b1;
                    end
                end
            end
            default: cmd_pop = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            walk_reg  <= walk_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LIST) |-> (CNT_W'(walk_reg) < count_reg))
        else $error("listing walk past held entries");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (out_data_next.status == ST_FULL)) |-> is_full)
        else $error("full status without a full store");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == BK_IDLE) && cmd_pop && is_push && !is_full)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted push did not grow the count");

endmodule

>>> src/double_ended_queue.sv
// Top level of the bounded double-ended queue.
// A bounded deque of signed 32-bit values held in a circular store of CAPACITY
// slots. Requests enter on the req channel and are decoded by a front end into a
// two-entry command queue; a back end executes them against the store and
// returns results on the rsp channel through an output register, so a waiting
// result never blocks request intake until the command queue fills. Unknown
// request codes are accepted and produce no result. In the back end, a push is
// answered straight from the command, a pop goes through a registered read of
// the store, and a listing returns one result per cycle after the first read
// while the rsp channel is not stalled; empty pops and empty listings are
// answered straight away. The store's single read port sets the listing rate.
// The store needs no clearing after reset: only counted entries are ever read.
module double_ended_queue #(
    parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dq_pkg::req_t  req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dq_pkg::rsp_t  rsp
);
    import dq_pkg::*;

    logic  fe_push;
    cmd_t  fe_cmd;
    logic  q_full;
    logic  q_not_empty;
    cmd_t  q_head;
    logic  be_pop;

    dq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_push  (fe_push),
        .cmd       (fe_cmd),
        .cmd_full  (q_full)
    );

    dq_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_push),
        .push_cmd  (fe_cmd),
        .full      (q_full),
        .pop       (be_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    dq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .cmd_pop   (be_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
